>>> rtl/key_state_overlay_compositor_core_assert.svh
`ifndef KEY_STATE_OVERLAY_COMPOSITOR_CORE_ASSERT_SVH
`define KEY_STATE_OVERLAY_COMPOSITOR_CORE_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger
`define KSOC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define KSOC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ksoc_pkg.sv
package ksoc_pkg;

   localparam int MAX_FRAME_DIM = 4096;
   localparam int NUM_KEYS      = 6;
   localparam int NUM_STAGES    = 1 + 3 * NUM_KEYS;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
   localparam int SETTLE_CYCLES = 5;

   localparam logic [12:0] RESET_WIDTH  = 13'd1920;
   localparam logic [12:0] RESET_HEIGHT = 13'd1080;

   localparam logic [7:0] BG_ALPHA   = 8'd140;
   localparam logic [7:0] BG_COLOR   = 8'd0;
   localparam logic [7:0] FILL_ALPHA = 8'd220;
   localparam logic [7:0] FILL_ON    = 8'd230;
   localparam logic [7:0] FILL_OFF   = 8'd64;
   localparam logic [7:0] RING_COLOR = 8'd255;
   localparam logic [7:0] RING_ALPHA = 8'd200;
   localparam logic [7:0] OPAQUE     = 8'd255;

   // reciprocals for small constant divisions
   localparam logic [16:0] RECIP_3  = 17'(65536 / 3);
   localparam logic [16:0] RECIP_5  = 17'(65536 / 5);
   localparam logic [16:0] RECIP_15 = 17'(65536 / 15);

   typedef logic signed [14:0] coord_type;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT,
      CSR_KEY_MASK,
      CSR_PIXEL_FORMAT
   } csr_index_type;

   typedef struct packed {
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [7:0]  blue_in;
      logic [7:0]  green_in;
      logic [7:0]  red_in;
      logic [7:0]  alpha_in;
   } req_type;

   typedef struct packed {
      logic [7:0] blue_out;
      logic [7:0] green_out;
      logic [7:0] red_out;
      logic [7:0] alpha_out;
   } rsp_type;

   typedef struct packed {
      logic [12:0]                w;
      logic [12:0]                h;
      logic [3:0]                 thick;
      coord_type                  bg_x;
      coord_type                  bg_y;
      coord_type                  bg_w;
      coord_type                  bg_h;
      coord_type [NUM_KEYS-1:0]   key_x;
      coord_type [NUM_KEYS-1:0]   key_y;
      coord_type [NUM_KEYS-1:0]   key_w;
      coord_type [NUM_KEYS-1:0]   key_h;
      coord_type [NUM_KEYS-1:0]   glyph_x;
      coord_type [NUM_KEYS-1:0]   glyph_y;
      coord_type [NUM_KEYS-1:0]   font_mult;
      coord_type                  glyph_w;
      coord_type                  glyph_h;
      logic [NUM_KEYS-1:0]        key_mask;
      logic                       gray;
   } layout_type;

   typedef struct packed {
      logic                       bg_en;
      logic [NUM_KEYS-1:0]        fill_en;
      logic [NUM_KEYS-1:0]        fill_on;
      logic [NUM_KEYS-1:0][1:0]   ring_cnt;
      logic [NUM_KEYS-1:0]        glyph_en;
      logic                       gray;
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
   } item_type;

   typedef struct packed {
      logic feed;
      logic advance;
   } back_status_type;

   // 5x7 glyph rows, bit 4 is the leftmost column: W, A, S, D
   localparam logic [4:0] GLYPH_ROWS [4][7] = '{
      '{5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h1B, 5'h11},
      '{5'h1E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
      '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E}
   };

   // Shift and Space show only their leading S
   localparam logic [1:0] KEY_GLYPH [NUM_KEYS] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd2};

   function automatic coord_type to_coord(input logic [12:0] v);
      return coord_type'({2'b00, v});
   endfunction

   function automatic coord_type cmax(input coord_type a, input coord_type b);
      return (a > b) ? a : b;
   endfunction

   // Divide a narrow value by a small constant through its reciprocal
   function automatic logic [9:0] div_const(input logic [9:0] v, input logic [4:0] d,
                                            input logic [16:0] recip);
      logic [26:0] prod;
      logic [9:0]  q;
      logic [14:0] rem;
      prod = 27'(v) * 27'(recip);
      q    = prod[25:16];
      rem  = 15'(v) - 15'(q) * 15'(d);
      if (rem >= 15'(d)) begin
         q = q + 10'd1;
      end
      return q;
   endfunction

   // floor((a*c + (255-a)*p) / 255)
   function automatic logic [7:0] blend8(input logic [7:0] p, input logic [7:0] a,
                                         input logic [7:0] c);
      logic [16:0] x;
      logic [16:0] y;
      x = 17'(a) * 17'(c) + 17'(8'd255 - a) * 17'(p);
      y = (x + 17'd1 + (x >> 8)) >> 8;
      return y[7:0];
   endfunction

   function automatic item_type blend_item(input item_type it, input logic [7:0] c,
                                           input logic [7:0] a);
      item_type r;
      r      = it;
      r.blue = blend8(it.blue, a, c);
      if (!it.op.gray) begin
         r.green = blend8(it.green, a, c);
         r.red   = blend8(it.red, a, c);
      end
      return r;
   endfunction

endpackage

>>> rtl/key_state_overlay_compositor_core.sv
// An accepted request is written into the queue, which hands it to the first of 19
// blend stages when the line advances; the last stage drives the result ports and the
// line holds while pop is low and a result waits there.
// Throughput: one request per cycle while full is low; the blend line advances whenever the
// output stage is empty or being popped, and a 4-entry queue decouples the sides.
// Reset: synchronous, active high; registers return to 1920x1080, no keys, BGRA.
// After reset and after each register write, full stays high while the layout settles.
`include "key_state_overlay_compositor_core_assert.svh"

module key_state_overlay_compositor_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  ksoc_pkg::req_type       req_data,
   input  logic                    pop,
   output logic                    empty,
   output ksoc_pkg::rsp_type       rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  ksoc_pkg::csr_index_type csr_index,
   input  logic [12:0]             csr_data
);

   ksoc_pkg::layout_type      lay;
   ksoc_pkg::item_type        fr_item, q_item;
   ksoc_pkg::back_status_type bk_status;
   logic                      lay_busy, q_full, q_valid, q_take;
   logic [ksoc_pkg::QUEUE_AW:0] q_count;

   assign csr_ready = 1'b1;
   assign full      = q_full || lay_busy;

   ksoc_layout u_layout (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .lay       (lay),
      .busy      (lay_busy)
   );

   ksoc_front u_front (
      .req  (req_data),
      .lay  (lay),
      .item (fr_item)
   );

   ksoc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (push && !full),
      .wr_item  (fr_item),
      .take     (q_take),
      .rd_item  (q_item),
      .rd_valid (q_valid),
      .q_full   (q_full),
      .count    (q_count)
   );

   ksoc_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_item (q_item),
      .q_valid(q_valid),
      .q_take (q_take),
      .pop    (pop),
      .empty  (empty),
      .rsp    (rsp_data),
      .status (bk_status)
   );

   `KSOC_ASSERT_NOW(a_settle_blocks_input, lay_busy, full, "request accepted during layout settle")
   `KSOC_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= 3'(ksoc_pkg::QUEUE_DEPTH), "queue overflow")
   `KSOC_ASSERT_NEXT(a_back_delivers, bk_status.feed && bk_status.advance, !empty, "result lost")

endmodule

>>> rtl/ksoc_layout.sv
module ksoc_layout (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  ksoc_pkg::csr_index_type csr_index,
   input  logic [12:0]             csr_data,
   output ksoc_pkg::layout_type    lay,
   output logic                    busy
);

   typedef struct packed {
      logic [12:0]         w;
      logic [12:0]         h;
      ksoc_pkg::coord_type pad;
      ksoc_pkg::coord_type box;
      ksoc_pkg::coord_type gap;
      logic [3:0]          thick;
   } s1_type;

   typedef struct packed {
      s1_type              a;
      ksoc_pkg::coord_type font;
      ksoc_pkg::coord_type hud_w;
      ksoc_pkg::coord_type hud_h;
      ksoc_pkg::coord_type bar_h;
   } s2_type;

   typedef struct packed {
      s2_type                                        b;
      ksoc_pkg::coord_type                           oy;
      ksoc_pkg::coord_type                           row_a;
      ksoc_pkg::coord_type                           f5;
      ksoc_pkg::coord_type                           f7;
      ksoc_pkg::coord_type                           off_kx;
      ksoc_pkg::coord_type                           off_ky;
      ksoc_pkg::coord_type                           off_by;
      ksoc_pkg::coord_type [ksoc_pkg::NUM_KEYS-1:0]  fm;
   } s3_type;

   logic [12:0] fw_ff, fw_in, fh_ff, fh_in;
   logic [ksoc_pkg::NUM_KEYS-1:0] km_ff, km_in;
   logic        fmt_ff, fmt_in;
   logic [2:0]  settle_ff, settle_in;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   ksoc_pkg::layout_type lay_ff, lay_in;

   // take register writes and restart the settle count
   always_comb begin
      fw_in     = fw_ff;
      fh_in     = fh_ff;
      km_in     = km_ff;
      fmt_in    = fmt_ff;
      settle_in = (settle_ff != 3'd0) ? settle_ff - 3'd1 : 3'd0;
      if (csr_valid) begin
         settle_in = 3'(ksoc_pkg::SETTLE_CYCLES);
         case (csr_index)
            ksoc_pkg::CSR_FRAME_WIDTH: begin
               fw_in = csr_data;
            end
            ksoc_pkg::CSR_FRAME_HEIGHT: begin
               fh_in = csr_data;
            end
            ksoc_pkg::CSR_KEY_MASK: begin
               km_in = csr_data[ksoc_pkg::NUM_KEYS-1:0];
            end
            ksoc_pkg::CSR_PIXEL_FORMAT: begin
               fmt_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff     <= ksoc_pkg::RESET_WIDTH;
         fh_ff     <= ksoc_pkg::RESET_HEIGHT;
         km_ff     <= '0;
         fmt_ff    <= 1'b0;
         settle_ff <= 3'(ksoc_pkg::SETTLE_CYCLES);
      end else begin
         fw_ff     <= fw_in;
         fh_ff     <= fh_in;
         km_ff     <= km_in;
         fmt_ff    <= fmt_in;
         settle_ff <= settle_in;
      end
   end

   // clamp frame size and derive the base sizes
   always_comb begin
      logic [12:0] wc;
      logic [9:0]  tq;
      wc       = (fw_ff > 13'(ksoc_pkg::MAX_FRAME_DIM)) ? 13'(ksoc_pkg::MAX_FRAME_DIM) : fw_ff;
      s1_in.w  = wc;
      s1_in.h  = (fh_ff > 13'(ksoc_pkg::MAX_FRAME_DIM)) ? 13'(ksoc_pkg::MAX_FRAME_DIM) : fh_ff;
      s1_in.pad = ksoc_pkg::cmax(ksoc_pkg::to_coord(wc >> 6), 15'sd20);
      s1_in.box = ksoc_pkg::cmax(ksoc_pkg::to_coord({3'b000,
                     ksoc_pkg::div_const(10'(wc >> 3), 5'd3, ksoc_pkg::RECIP_3)}), 15'sd64);
      s1_in.gap = ksoc_pkg::cmax(ksoc_pkg::to_coord({3'b000,
                     ksoc_pkg::div_const(10'(wc >> 5), 5'd5, ksoc_pkg::RECIP_5)}), 15'sd10);
      tq        = ksoc_pkg::div_const(10'(wc >> 5), 5'd15, ksoc_pkg::RECIP_15);
      s1_in.thick = (tq < 10'd3) ? 4'd3 : tq[3:0];
   end

   // font size and panel extent
   always_comb begin
      s2_in.a     = s1_ff;
      s2_in.font  = ksoc_pkg::cmax(ksoc_pkg::to_coord({3'b000,
                       ksoc_pkg::div_const(10'(s1_ff.box >>> 1), 5'd5, ksoc_pkg::RECIP_5)}),
                       15'sd3);
      s2_in.hud_w = (s1_ff.box <<< 1) + s1_ff.box + (s1_ff.gap <<< 1);
      s2_in.hud_h = (s1_ff.box <<< 1) + (s1_ff.gap <<< 1) + s1_ff.gap
                    + ((s1_ff.box >>> 1) <<< 1);
      s2_in.bar_h = s1_ff.box >>> 1;
   end

   // panel origin and glyph offsets
   always_comb begin
      ksoc_pkg::coord_type d;
      s3_in.b      = s2_ff;
      s3_in.oy     = ksoc_pkg::to_coord(s2_ff.a.h) - s2_ff.a.pad - s2_ff.hud_h;
      s3_in.row_a  = s3_in.oy + s2_ff.a.box + s2_ff.a.gap;
      s3_in.f5     = (s2_ff.font <<< 2) + s2_ff.font;
      s3_in.f7     = (s2_ff.font <<< 3) - s2_ff.font;
      s3_in.off_kx = (s2_ff.a.box - s3_in.f5) >>> 1;
      s3_in.off_ky = (s2_ff.a.box - s3_in.f7) >>> 1;
      // round toward zero when the bar is shorter than the glyph
      d            = s2_ff.bar_h - s3_in.f7;
      s3_in.off_by = (d + ksoc_pkg::coord_type'({14'd0, d[14]})) >>> 1;
      for (int i = 0; i < ksoc_pkg::NUM_KEYS; i++) begin
         s3_in.fm[i] = ksoc_pkg::coord_type'(s2_ff.font * (i + 1));
      end
   end

   // key rectangles and glyph origins
   always_comb begin
      ksoc_pkg::coord_type ox, bg, sh_y, sp_y;
      ox   = s3_ff.b.a.pad;
      bg   = s3_ff.b.a.box + s3_ff.b.a.gap;
      sh_y = s3_ff.row_a + bg;
      sp_y = sh_y + s3_ff.b.bar_h + s3_ff.b.a.gap;
      lay_in.w        = s3_ff.b.a.w;
      lay_in.h        = s3_ff.b.a.h;
      lay_in.thick    = s3_ff.b.a.thick;
      lay_in.bg_x     = ox - 15'sd6;
      lay_in.bg_y     = s3_ff.oy - 15'sd6;
      lay_in.bg_w     = s3_ff.b.hud_w + 15'sd12;
      lay_in.bg_h     = s3_ff.b.hud_h + 15'sd12;
      lay_in.key_x[0] = ox + bg;
      lay_in.key_x[1] = ox;
      lay_in.key_x[2] = ox + bg;
      lay_in.key_x[3] = ox + (bg <<< 1);
      lay_in.key_x[4] = ox;
      lay_in.key_x[5] = ox;
      lay_in.key_y[0] = s3_ff.oy;
      lay_in.key_y[1] = s3_ff.row_a;
      lay_in.key_y[2] = s3_ff.row_a;
      lay_in.key_y[3] = s3_ff.row_a;
      lay_in.key_y[4] = sh_y;
      lay_in.key_y[5] = sp_y;
      for (int k = 0; k < ksoc_pkg::NUM_KEYS; k++) begin
         if (k < 4) begin
            lay_in.key_w[k]   = s3_ff.b.a.box;
            lay_in.key_h[k]   = s3_ff.b.a.box;
            lay_in.glyph_x[k] = lay_in.key_x[k] + s3_ff.off_kx;
            lay_in.glyph_y[k] = lay_in.key_y[k] + s3_ff.off_ky;
         end else begin
            lay_in.key_w[k]   = s3_ff.b.hud_w;
            lay_in.key_h[k]   = s3_ff.b.bar_h;
            lay_in.glyph_x[k] = lay_in.key_x[k] + 15'sd8;
            lay_in.glyph_y[k] = lay_in.key_y[k] + s3_ff.off_by;
         end
      end
      lay_in.font_mult = s3_ff.fm;
      lay_in.glyph_w   = s3_ff.f5;
      lay_in.glyph_h   = s3_ff.f7;
      lay_in.key_mask  = km_ff;
      lay_in.gray      = fmt_ff;
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      s3_ff  <= s3_in;
      lay_ff <= lay_in;
   end

   assign lay  = lay_ff;
   assign busy = (settle_ff != 3'd0);

endmodule

>>> rtl/ksoc_front.sv
module ksoc_front (
   input  ksoc_pkg::req_type    req,
   input  ksoc_pkg::layout_type lay,
   output ksoc_pkg::item_type   item
);

   // classify the pixel against every layer of the panel
   always_comb begin
      ksoc_pkg::coord_type px, py, th, kx, ky, kw, kh, dx, dy, ex, ey, gdx, gdy, fm;
      logic        in_frame, r0, r1, r2, r3, ghit, touched;
      logic [2:0]  cnt, gx, gy;
      logic [4:0]  row;
      px       = ksoc_pkg::to_coord({1'b0, req.pixel_x});
      py       = ksoc_pkg::to_coord({1'b0, req.pixel_y});
      th       = ksoc_pkg::to_coord({9'd0, lay.thick});
      in_frame = ({1'b0, req.pixel_x} < lay.w) && ({1'b0, req.pixel_y} < lay.h);
      item.op  = '0;
      item.op.gray    = lay.gray;
      item.op.fill_on = lay.key_mask;

      // background
      kx = lay.bg_x;
      ky = lay.bg_y;
      kw = lay.bg_w;
      kh = lay.bg_h;
      dx = px - kx;
      dy = py - ky;
      ex = kx + kw - 15'sd1 - px;
      ey = ky + kh - 15'sd1 - py;
      item.op.bg_en = in_frame && dx >= 0 && dy >= 0 && ex >= 0 && ey >= 0;

      for (int k = 0; k < ksoc_pkg::NUM_KEYS; k++) begin
         kx = lay.key_x[k];
         ky = lay.key_y[k];
         kw = lay.key_w[k];
         kh = lay.key_h[k];
         dx = px - kx;
         dy = py - ky;
         ex = kx + kw - 15'sd1 - px;
         ey = ky + kh - 15'sd1 - py;
         item.op.fill_en[k] = in_frame && dx >= 0 && dy >= 0 && ex >= 0 && ey >= 0;

         // ring hits: top, bottom, left, right edges of each ring
         r0  = dy >= 0 && dy < th && dx >= dy && ex >= dy;
         r1  = ey >= 0 && ey < th && dx >= ey && ex >= ey;
         r2  = dx >= 0 && dx < th && dy >= dx && ey >= dx;
         r3  = ex >= 0 && ex < th && dy >= ex && ey >= ex;
         cnt = 3'(r0) + 3'(r1) + 3'(r2) + 3'(r3);
         item.op.ring_cnt[k] = in_frame ? cnt[1:0] : 2'd0;

         // glyph cell by comparing against multiples of the font size
         kx   = lay.glyph_x[k];
         ky   = lay.glyph_y[k];
         gdx  = px - kx;
         gdy  = py - ky;
         kw   = lay.glyph_w;
         kh   = lay.glyph_h;
         ghit = gdx >= 0 && gdy >= 0 && gdx < kw && gdy < kh;
         gx   = 3'd0;
         gy   = 3'd0;
         for (int j = 0; j < ksoc_pkg::NUM_KEYS; j++) begin
            fm = lay.font_mult[j];
            if (j < 4) begin
               gx = gx + 3'(gdx >= fm);
            end
            gy = gy + 3'(gdy >= fm);
         end
         row = ghit ? ksoc_pkg::GLYPH_ROWS[ksoc_pkg::KEY_GLYPH[k]][gy] : 5'd0;
         item.op.glyph_en[k] = in_frame && ghit && row[3'd4 - gx];
      end

      touched    = item.op.bg_en || (|item.op.fill_en) || (|item.op.ring_cnt)
                   || (|item.op.glyph_en);
      item.blue  = req.blue_in;
      item.green = req.green_in;
      item.red   = req.red_in;
      item.alpha = (!lay.gray && touched) ? ksoc_pkg::OPAQUE : req.alpha_in;
   end

endmodule

>>> rtl/ksoc_queue.sv
module ksoc_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  ksoc_pkg::item_type             wr_item,
   input  logic                           take,
   output ksoc_pkg::item_type             rd_item,
   output logic                           rd_valid,
   output logic                           q_full,
   output logic [ksoc_pkg::QUEUE_AW:0]    count
);

   ksoc_pkg::item_type mem_ff [ksoc_pkg::QUEUE_DEPTH];
   logic [ksoc_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [ksoc_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic do_wr, do_rd;

   function automatic logic [ksoc_pkg::QUEUE_AW:0] QUEUE_AW_ONE(input logic b);
      return {{ksoc_pkg::QUEUE_AW{1'b0}}, b};
   endfunction

   assign do_wr = wr_en && !q_full;
   assign do_rd = take && rd_valid;

   // advance pointers and count
   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + ksoc_pkg::QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + ksoc_pkg::QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW_ONE(do_wr)) - (QUEUE_AW_ONE(do_rd));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold request entries
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   assign rd_item  = mem_ff[rd_ptr_ff];
   assign rd_valid = (count_ff != '0);
   assign q_full   = (count_ff == (ksoc_pkg::QUEUE_AW + 1)'(ksoc_pkg::QUEUE_DEPTH));
   assign count    = count_ff;

endmodule

>>> rtl/ksoc_back.sv
module ksoc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ksoc_pkg::item_type         q_item,
   input  logic                       q_valid,
   output logic                       q_take,
   input  logic                       pop,
   output logic                       empty,
   output ksoc_pkg::rsp_type          rsp,
   output ksoc_pkg::back_status_type  status
);

   localparam int LAST = ksoc_pkg::NUM_STAGES - 1;

   ksoc_pkg::item_type pl_ff [ksoc_pkg::NUM_STAGES];
   ksoc_pkg::item_type st_in [ksoc_pkg::NUM_STAGES];
   logic [ksoc_pkg::NUM_STAGES-1:0] vld_ff, vld_in;
   logic adv;

   // move the whole line while the output slot is free or drained
   assign adv    = !vld_ff[LAST] || pop;
   assign q_take = adv && q_valid;

   // one blend per stage: background, then fill, ring, ring plus glyph per key
   always_comb begin
      st_in[0] = q_item.op.bg_en
                 ? ksoc_pkg::blend_item(q_item, ksoc_pkg::BG_COLOR, ksoc_pkg::BG_ALPHA)
                 : q_item;
      for (int k = 0; k < ksoc_pkg::NUM_KEYS; k++) begin
         st_in[1 + 3*k] = pl_ff[3*k];
         if (pl_ff[3*k].op.fill_en[k]) begin
            st_in[1 + 3*k] = ksoc_pkg::blend_item(pl_ff[3*k],
               pl_ff[3*k].op.fill_on[k] ? ksoc_pkg::FILL_ON : ksoc_pkg::FILL_OFF,
               ksoc_pkg::FILL_ALPHA);
         end
         st_in[2 + 3*k] = pl_ff[1 + 3*k];
         if (pl_ff[1 + 3*k].op.ring_cnt[k] != 2'd0) begin
            st_in[2 + 3*k] = ksoc_pkg::blend_item(pl_ff[1 + 3*k], ksoc_pkg::RING_COLOR,
                                                  ksoc_pkg::RING_ALPHA);
         end
         // ring corners take a second blend
         st_in[3 + 3*k] = pl_ff[2 + 3*k];
         if (pl_ff[2 + 3*k].op.ring_cnt[k] == 2'd2) begin
            st_in[3 + 3*k] = ksoc_pkg::blend_item(pl_ff[2 + 3*k], ksoc_pkg::RING_COLOR,
                                                  ksoc_pkg::RING_ALPHA);
         end
         // opaque black glyph drops blue, and green and red unless gray, to zero
         if (pl_ff[2 + 3*k].op.glyph_en[k]) begin
            st_in[3 + 3*k].blue = 8'd0;
            if (!pl_ff[2 + 3*k].op.gray) begin
               st_in[3 + 3*k].green = 8'd0;
               st_in[3 + 3*k].red   = 8'd0;
            end
         end
      end
   end

   always_comb begin
      vld_in = {vld_ff[LAST-1:0], q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < ksoc_pkg::NUM_STAGES; s++) begin
            pl_ff[s] <= st_in[s];
         end
      end
   end

   assign empty          = !vld_ff[LAST];
   assign rsp.blue_out   = pl_ff[LAST].blue;
   assign rsp.green_out  = pl_ff[LAST].green;
   assign rsp.red_out    = pl_ff[LAST].red;
   assign rsp.alpha_out  = pl_ff[LAST].alpha;
   assign status.feed    = vld_ff[LAST-1];
   assign status.advance = adv;

endmodule

>>> tb/key_state_overlay_compositor_checker.sv
`timescale 1ns / 100ps

module key_state_overlay_compositor_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic                    full,
   input  ksoc_pkg::req_type       req_data,
   input  logic                    pop,
   input  logic                    empty,
   input  ksoc_pkg::rsp_type       rsp_data,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  ksoc_pkg::csr_index_type csr_index,
   input  logic [12:0]             csr_data,
   output int                      fail_count,
   output int                      pending
);

   // 5x7 letter rows, bit 4 is the leftmost column: W, A, S, D
   localparam logic [4:0] LETTER_ROWS [4][7] = '{
      '{5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h1B, 5'h11},
      '{5'h1E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
      '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E}
   };
   localparam int KEY_LETTER [6] = '{0, 1, 2, 3, 2, 2};

   logic [12:0] cfg_width;
   logic [12:0] cfg_height;
   logic [5:0]  cfg_keys;
   logic        cfg_gray;

   ksoc_pkg::rsp_type pixel_q [$];

   logic [7:0]  chan [3];
   logic        touched;

   function automatic int imax(input int a, input int b);
      return a > b ? a : b;
   endfunction

   // blend all channels toward one color, the given number of times
   task automatic paint(input int c, input int a, input int times);
      for (int n = 0; n < times; n++) begin
         for (int k = 0; k < 3; k++)
            chan[k] = 8'((a * c + (255 - a) * int'(chan[k])) / 255);
         touched = 1'b1;
      end
   endtask

   function automatic bit in_rect(input int px, input int py, input int x0, input int y0,
                                  input int w, input int h);
      return px >= x0 && px < x0 + w && py >= y0 && py < y0 + h;
   endfunction

   function automatic int ring_count(input int px, input int py, input int x0, input int y0,
                                     input int w, input int h, input int thick);
      int hits;
      int x1;
      int y1;
      hits = 0;
      for (int t = 0; t < thick; t++) begin
         x1 = x0 + w - 1 - t;
         y1 = y0 + h - 1 - t;
         if (px >= x0 + t && px <= x1)
            hits += int'(py == y0 + t) + int'(py == y1);
         if (py >= y0 + t && py <= y1)
            hits += int'(px == x0 + t) + int'(px == x1);
      end
      return hits;
   endfunction

   function automatic bit letter_hit(input int px, input int py, input int tx, input int ty,
                                     input int scale, input int g);
      int dx;
      int dy;
      dx = px - tx;
      dy = py - ty;
      if (dx < 0 || dy < 0 || dx >= 5 * scale || dy >= 7 * scale)
         return 1'b0;
      return LETTER_ROWS[g][dy / scale][4 - dx / scale];
   endfunction

   // composite the key panel over one pixel
   task automatic composite(input ksoc_pkg::req_type rq, output ksoc_pkg::rsp_type rs);
      int px, py, fw, fh;
      int pad, box, gap, thick, font, hud_w, hud_h, ox, oy, row_a, sh_y, bar_h, sp_y;
      int kx [6];
      int ky [6];
      int kw, kh, tx, ty;
      px = rq.pixel_x;
      py = rq.pixel_y;
      fw = cfg_width > ksoc_pkg::MAX_FRAME_DIM ? ksoc_pkg::MAX_FRAME_DIM : int'(cfg_width);
      fh = cfg_height > ksoc_pkg::MAX_FRAME_DIM ? ksoc_pkg::MAX_FRAME_DIM : int'(cfg_height);
      chan[0] = rq.blue_in;
      chan[1] = rq.green_in;
      chan[2] = rq.red_in;
      touched = 1'b0;
      if (px < fw && py < fh) begin
         pad = imax(20, fw / 64);
         box = imax(64, fw / 24);
         gap = imax(10, fw / 160);
         thick = imax(3, fw / 480);
         font = imax(3, box / 10);
         hud_w = box * 3 + gap * 2;
         hud_h = box * 2 + gap * 3 + (box / 2) * 2;
         ox = pad;
         oy = fh - pad - hud_h;
         row_a = oy + box + gap;
         sh_y = row_a + box + gap;
         bar_h = box / 2;
         sp_y = sh_y + bar_h + gap;
         kx = '{ox + box + gap, ox, ox + box + gap, ox + (box + gap) * 2, ox, ox};
         ky = '{oy, row_a, row_a, row_a, sh_y, sp_y};
         if (in_rect(px, py, ox - 6, oy - 6, hud_w + 12, hud_h + 12))
            paint(0, 140, 1);
         for (int k = 0; k < 6; k++) begin
            kw = k < 4 ? box : hud_w;
            kh = k < 4 ? box : bar_h;
            if (in_rect(px, py, kx[k], ky[k], kw, kh))
               paint(cfg_keys[k] ? 230 : 64, 220, 1);
            paint(255, 200, ring_count(px, py, kx[k], ky[k], kw, kh, thick));
            if (k < 4) begin
               tx = kx[k] + (box - 5 * font) / 2;
               ty = ky[k] + (box - 7 * font) / 2;
            end else begin
               tx = kx[k] + 8;
               ty = ky[k] + (bar_h - 7 * font) / 2;
            end
            if (letter_hit(px, py, tx, ty, font, KEY_LETTER[k]))
               paint(0, 255, 1);
         end
      end
      rs.blue_out = chan[0];
      if (!cfg_gray) begin
         rs.green_out = chan[1];
         rs.red_out   = chan[2];
         rs.alpha_out = touched ? 8'd255 : rq.alpha_in;
      end else begin
         rs.green_out = rq.green_in;
         rs.red_out   = rq.red_in;
         rs.alpha_out = rq.alpha_in;
      end
   endtask

   task automatic report(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // track registers, queue predictions, compare results
   always @(posedge clock) begin
      ksoc_pkg::rsp_type want;
      if (reset) begin
         cfg_width  <= ksoc_pkg::RESET_WIDTH;
         cfg_height <= ksoc_pkg::RESET_HEIGHT;
         cfg_keys   <= '0;
         cfg_gray   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ksoc_pkg::CSR_FRAME_WIDTH: cfg_width <= csr_data;
               ksoc_pkg::CSR_FRAME_HEIGHT: cfg_height <= csr_data;
               ksoc_pkg::CSR_KEY_MASK: cfg_keys <= csr_data[5:0];
               ksoc_pkg::CSR_PIXEL_FORMAT: cfg_gray <= csr_data[0];
               default: ;
            endcase
         end
         if (push && !full) begin
            composite(req_data, want);
            pixel_q.push_back(want);
         end
         if (pop && !empty) begin
            if (pixel_q.size() == 0) begin
               report("result with no request pending", 1, 0);
            end else begin
               want = pixel_q.pop_front();
               if (rsp_data.blue_out !== want.blue_out)
                  report("blue_out", rsp_data.blue_out, want.blue_out);
               if (rsp_data.green_out !== want.green_out)
                  report("green_out", rsp_data.green_out, want.green_out);
               if (rsp_data.red_out !== want.red_out)
                  report("red_out", rsp_data.red_out, want.red_out);
               if (rsp_data.alpha_out !== want.alpha_out)
                  report("alpha_out", rsp_data.alpha_out, want.alpha_out);
            end
         end
         pending = pixel_q.size();
      end
   end

endmodule

>>> tb/key_state_overlay_compositor_core_tb.sv
`timescale 1ns / 100ps

module key_state_overlay_compositor_core_tb;

   logic                    clock;
   logic                    reset;
   logic                    push;
   logic                    full;
   ksoc_pkg::req_type       req_data;
   logic                    pop;
   logic                    empty;
   ksoc_pkg::rsp_type       rsp_data;
   logic                    csr_valid;
   logic                    csr_ready;
   ksoc_pkg::csr_index_type csr_index;
   logic [12:0]             csr_data;
   int                      fail_count;
   int                      pending;
   bit                      hold_request;
   bit                      holding;
   int                      cur_w;
   int                      cur_h;

   key_state_overlay_compositor_core dut (.*);

   key_state_overlay_compositor_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // receiver: random stall pattern, plus one long hold-off on request
   initial begin
      int cnt;
      pop = 1'b0;
      holding = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !holding) begin
            holding = 1'b1;
            pop <= 1'b0;
            for (cnt = 0; cnt < 300; cnt++)
               @(negedge clock);
         end
         case ($urandom_range(0, 3))
            0: pop <= ($urandom_range(0, 3) == 0);
            1: pop <= ($urandom_range(0, 1) == 0);
            default: pop <= 1'b1;
         endcase
      end
   end

   // hold one request on the port until it is taken
   task automatic send_pixel(input int px, input int py);
      ksoc_pkg::req_type rq;
      rq.pixel_x  = 12'(px);
      rq.pixel_y  = 12'(py);
      rq.blue_in  = 8'($urandom);
      rq.green_in = 8'($urandom);
      rq.red_in   = 8'($urandom);
      rq.alpha_in = 8'($urandom);
      @(negedge clock);
      push <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (full);
   endtask

   task automatic idle_gap(input int n);
      @(negedge clock);
      push <= 1'b0;
      for (int i = 1; i < n; i++)
         @(negedge clock);
   endtask

   // drain, then write one register
   task automatic write_reg(input ksoc_pkg::csr_index_type idx, input int val);
      @(negedge clock);
      push <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (30) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= 13'(val);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == ksoc_pkg::CSR_FRAME_WIDTH) cur_w = val;
      if (idx == ksoc_pkg::CSR_FRAME_HEIGHT) cur_h = val;
   endtask

   // pick a pixel: mostly around the panel, sometimes anywhere
   task automatic pick_pixel(output int px, output int py);
      int fw, fh, pad, box, gap, hud_w, hud_h;
      fw = cur_w > 4096 ? 4096 : (cur_w < 1 ? 1 : cur_w);
      fh = cur_h > 4096 ? 4096 : (cur_h < 1 ? 1 : cur_h);
      pad = fw / 64 > 20 ? fw / 64 : 20;
      box = fw / 24 > 64 ? fw / 24 : 64;
      gap = fw / 160 > 10 ? fw / 160 : 10;
      hud_w = box * 3 + gap * 2;
      hud_h = box * 2 + gap * 3 + (box / 2) * 2;
      if ($urandom_range(0, 6) == 0) begin
         px = $urandom_range(0, 4095);
         py = $urandom_range(0, 4095);
      end else begin
         px = $urandom_range(0, pad + hud_w + 10);
         py = fh - pad - hud_h - 10 + $urandom_range(0, hud_h + pad + 20);
         if (py < 0) py = $urandom_range(0, 80);
         if (py > 4095) py = 4095;
         if (px > 4095) px = 4095;
      end
   endtask

   task automatic random_burst_run(input int count, input bit with_hold);
      int px, py, sent, burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         if (with_hold && sent > count / 3 && !holding)
            hold_request = 1'b1;
         for (int i = 0; i < burst && sent < count; i++) begin
            pick_pixel(px, py);
            send_pixel(px, py);
            sent++;
         end
         if ($urandom_range(0, 2) != 0)
            idle_gap($urandom_range(1, 12));
      end
   endtask

   initial begin
      int cycles;
      push = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = ksoc_pkg::CSR_FRAME_WIDTH;
      csr_data = '0;
      hold_request = 1'b0;
      cur_w = 1920;
      cur_h = 1080;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extreme coordinates and panel edges at reset layout
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(1919, 1079);
      send_pixel(1920, 500);
      send_pixel(30, 1080);
      send_pixel(30, 739);
      send_pixel(24, 733);
      send_pixel(23, 732);
      send_pixel(110, 764);
      send_pixel(112, 766);
      send_pixel(30, 844);
      send_pixel(32, 846);
      send_pixel(40, 870);
      send_pixel(38, 935);
      send_pixel(40, 990);
      send_pixel(45, 1010);
      idle_gap(3);
      write_reg(ksoc_pkg::CSR_KEY_MASK, 63);
      send_pixel(35, 850);
      send_pixel(145, 800);
      send_pixel(40, 1000);
      write_reg(ksoc_pkg::CSR_PIXEL_FORMAT, 1);
      send_pixel(35, 850);
      send_pixel(4095, 0);
      write_reg(ksoc_pkg::CSR_PIXEL_FORMAT, 0);

      // random phases over several layouts
      random_burst_run(250, 1'b1);
      write_reg(ksoc_pkg::CSR_FRAME_WIDTH, 4096);
      write_reg(ksoc_pkg::CSR_FRAME_HEIGHT, 4096);
      write_reg(ksoc_pkg::CSR_KEY_MASK, $urandom_range(0, 63));
      random_burst_run(220, 1'b0);
      write_reg(ksoc_pkg::CSR_FRAME_WIDTH, 8191);
      write_reg(ksoc_pkg::CSR_FRAME_HEIGHT, 5000);
      write_reg(ksoc_pkg::CSR_PIXEL_FORMAT, 1);
      random_burst_run(180, 1'b0);
      write_reg(ksoc_pkg::CSR_FRAME_WIDTH, 1);
      write_reg(ksoc_pkg::CSR_FRAME_HEIGHT, 1);
      write_reg(ksoc_pkg::CSR_PIXEL_FORMAT, 0);
      random_burst_run(60, 1'b0);
      write_reg(ksoc_pkg::CSR_FRAME_WIDTH, 0);
      write_reg(ksoc_pkg::CSR_FRAME_HEIGHT, 0);
      random_burst_run(40, 1'b0);
      write_reg(ksoc_pkg::CSR_FRAME_WIDTH, 200);
      write_reg(ksoc_pkg::CSR_FRAME_HEIGHT, 150);
      write_reg(ksoc_pkg::CSR_KEY_MASK, 0);
      random_burst_run(220, 1'b0);
      write_reg(ksoc_pkg::CSR_FRAME_WIDTH, 640);
      write_reg(ksoc_pkg::CSR_FRAME_HEIGHT, 480);
      write_reg(ksoc_pkg::CSR_KEY_MASK, $urandom_range(0, 63));
      random_burst_run(240, 1'b0);
      write_reg(ksoc_pkg::CSR_FRAME_WIDTH, 2560);
      write_reg(ksoc_pkg::CSR_FRAME_HEIGHT, 1440);
      write_reg(ksoc_pkg::CSR_PIXEL_FORMAT, 1);
      write_reg(ksoc_pkg::CSR_KEY_MASK, 42);
      random_burst_run(220, 1'b0);

      // drain and settle
      idle_gap(1);
      cycles = 0;
      while (pending != 0 && cycles < 20000) begin
         @(negedge clock);
         cycles++;
      end
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
